[src/ajb_pkg.sv]
package ajb_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int MAX_PAYLOAD = 256;
    localparam int OFF_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 9;
    localparam int MAX_PULL    = 64;
    localparam int NEED_W      = 7;
    localparam int SEQ_W       = 32;
    localparam int PAY_AW      = SLOT_W + OFF_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SEQ_W-1:0] MAX_GAP_RESET = 32'd16;

    typedef enum logic [1:0] {
        KIND_PUSH_BEGIN = 2'd0,
        KIND_PUSH_BYTE  = 2'd1,
        KIND_PULL       = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_EXPIRED   = 2'd1,
        ST_DUPLICATE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SRC_STATUS = 2'd0,
        SRC_ZERO   = 2'd1,
        SRC_LEFT   = 2'd2,
        SRC_PAY    = 2'd3
    } src_t;

    typedef struct packed {
        logic    start_push;
        logic    push_byte;
        logic    start_pull;
        logic    base_lower;
        logic    store_free;
        logic    scan_start;
        logic    scan_floor_exp;
        logic    evict;
        logic    base_from_scan;
        logic    emit;
        src_t    emit_src;
        status_t emit_status;
        logic    lo_rd;
        logic    sync_exp;
        logic    find;
        logic    pl_rd;
        logic    lc_wr;
        logic    consume;
        logic    jump;
        logic    miss;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic need_zero;
        logic expired;
        logic dup;
        logic any_free;
        logic scan_busy;
        logic erased_is_base;
        logic lo_nonempty;
        logic filled_done;
        logic hit;
        logic off_lt_copy;
        logic off_lt_len;
        logic jump_ok;
        logic out_free;
    } sts_t;

    function automatic logic seq_older(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

[src/ajb_ctrl.sv]
module ajb_ctrl
    import ajb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PB_CHK,
        S_PB_SCAN,
        S_PB_EVB,
        S_PB_SCAN2,
        S_ST_EMIT,
        S_LO_CHK,
        S_LO_EMIT,
        S_FIND,
        S_CP_CHK,
        S_CP_EMIT,
        S_LC_WR,
        S_MS_SCAN,
        S_Z_FILL
    } state_t;

    state_t  state_reg, state_next;
    status_t stat_reg, stat_next;
    logic    accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.emit_status = stat_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        KIND_PUSH_BEGIN: begin
                            cmd.start_push = 1'b1;
                            state_next     = S_PB_CHK;
                        end
                        KIND_PUSH_BYTE: begin
                            cmd.push_byte = 1'b1;
                        end
                        KIND_PULL: begin
                            if (!sts.need_zero) begin
                                cmd.start_pull = 1'b1;
                                state_next     = sts.started ? S_LO_CHK : S_Z_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PB_CHK: begin
                if (sts.expired) begin
                    stat_next  = ST_EXPIRED;
                    state_next = S_ST_EMIT;
                end else if (sts.dup) begin
                    stat_next  = ST_DUPLICATE;
                    state_next = S_ST_EMIT;
                end else if (sts.any_free) begin
                    cmd.base_lower = 1'b1;
                    cmd.store_free = 1'b1;
                    stat_next      = ST_ACCEPTED;
                    state_next     = S_ST_EMIT;
                end else begin
                    cmd.base_lower = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_PB_SCAN;
                end
            end
            S_PB_SCAN: begin
                if (!sts.scan_busy) begin
                    cmd.evict  = 1'b1;
                    state_next = S_PB_EVB;
                end
            end
            S_PB_EVB: begin
                stat_next = ST_ACCEPTED;
                if (sts.erased_is_base) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_PB_SCAN2;
                end else begin
                    state_next = S_ST_EMIT;
                end
            end
            S_PB_SCAN2: begin
                if (!sts.scan_busy) begin
                    cmd.base_from_scan = 1'b1;
                    state_next         = S_ST_EMIT;
                end
            end
            S_ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_STATUS;
                    state_next   = S_IDLE;
                end
            end
            S_LO_CHK: begin
                if (sts.lo_nonempty && !sts.filled_done) begin
                    cmd.lo_rd  = 1'b1;
                    state_next = S_LO_EMIT;
                end else begin
                    cmd.sync_exp = 1'b1;
                    state_next   = S_FIND;
                end
            end
            S_LO_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_LEFT;
                    state_next   = S_LO_CHK;
                end
            end
            S_FIND: begin
                if (sts.filled_done) begin
                    state_next = S_IDLE;
                end else if (sts.hit) begin
                    cmd.find   = 1'b1;
                    state_next = S_CP_CHK;
                end else begin
                    cmd.scan_start     = 1'b1;
                    cmd.scan_floor_exp = 1'b1;
                    state_next         = S_MS_SCAN;
                end
            end
            S_CP_CHK: begin
                if (sts.off_lt_copy) begin
                    cmd.pl_rd  = 1'b1;
                    state_next = S_CP_EMIT;
                end else if (sts.off_lt_len) begin
                    cmd.pl_rd  = 1'b1;
                    state_next = S_LC_WR;
                end else begin
                    cmd.consume = 1'b1;
                    state_next  = S_FIND;
                end
            end
            S_CP_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_PAY;
                    state_next   = S_CP_CHK;
                end
            end
            S_LC_WR: begin
                cmd.lc_wr  = 1'b1;
                state_next = S_CP_CHK;
            end
            S_MS_SCAN: begin
                if (!sts.scan_busy) begin
                    if (sts.jump_ok) begin
                        cmd.jump   = 1'b1;
                        state_next = S_FIND;
                    end else begin
                        cmd.miss   = 1'b1;
                        state_next = S_Z_FILL;
                    end
                end
            end
            S_Z_FILL: begin
                if (sts.filled_done) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_ZERO;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stat_reg  <= ST_ACCEPTED;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

[src/ajb_dp.sv]
module ajb_dp
    import ajb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   cfg_we,
    input  logic [SEQ_W-1:0]       cfg_wdata,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_kind,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last
);

    logic [SEQ_W-1:0]  in_seq;
    logic [LEN_W-1:0]  in_len, in_len_sat;
    logic [7:0]        in_byte;
    logic [NEED_W-1:0] in_need, in_need_sat;

    assign in_seq  = in_data[31:0];
    assign in_len  = in_data[40:32];
    assign in_byte = in_data[48:41];
    assign in_need = in_data[55:49];

    assign in_len_sat  = (in_len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len;
    assign in_need_sat = (in_need > NEED_W'(MAX_PULL)) ? NEED_W'(MAX_PULL) : in_need;

    logic [SEQ_W-1:0]  max_gap_reg;
    logic              started_reg;
    logic [SEQ_W-1:0]  base_reg, exp_reg;
    logic              parity_reg;
    logic [SLOT_W-1:0] fill_slot_reg;
    logic [LEN_W-1:0]  fill_count_reg;
    logic              fill_active_reg;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SEQ_W-1:0]  slot_seq_reg [SLOTS];
    logic [LEN_W-1:0]  slot_len_reg [SLOTS];
    logic [OFF_W-1:0]  lo_start_reg;
    logic [LEN_W-1:0]  lo_count_reg;

    logic [SEQ_W-1:0]  s_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [NEED_W-1:0] need_reg, filled_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [LEN_W-1:0]  hit_len_reg, copy_reg, off_reg;
    logic [OFF_W-1:0]  wr_idx_reg;
    logic              erased_base_reg;

    logic              scan_busy_reg, best_found_reg;
    logic [SLOT_W-1:0] scan_idx_reg, best_idx_reg;
    logic [SEQ_W-1:0]  best_seq_reg, floor_reg;

    logic [7:0]        payload_mem [SLOTS*MAX_PAYLOAD];
    logic [7:0]        leftover_mem [MAX_PAYLOAD];
    logic [7:0]        pl_rdata_reg, lo_rdata_reg;

    logic              out_valid_reg, out_kind_reg, out_last_reg;
    logic [1:0]        out_status_reg;
    logic [7:0]        out_byte_reg;

    logic              free_found, dup_found, exp_found;
    logic [SLOT_W-1:0] free_idx, exp_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        dup_found  = 1'b0;
        exp_found  = 1'b0;
        exp_idx    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (slot_valid_reg[i] && slot_seq_reg[i] == s_reg) begin
                dup_found = 1'b1;
            end
            if (slot_valid_reg[i] && slot_seq_reg[i] == exp_reg) begin
                exp_found = 1'b1;
                exp_idx   = SLOT_W'(i);
            end
        end
    end

    logic [LEN_W-1:0]  room, copy_calc;
    logic              scan_take;
    logic [SEQ_W-1:0]  gap;
    logic [SEQ_W-1:0]  erased;
    logic              out_free;

    assign room      = LEN_W'(need_reg - filled_reg);
    assign copy_calc = (slot_len_reg[exp_idx] < room) ? slot_len_reg[exp_idx] : room;
    assign scan_take = slot_valid_reg[scan_idx_reg] && (slot_seq_reg[scan_idx_reg] >= floor_reg)
                       && (!best_found_reg || slot_seq_reg[scan_idx_reg] < best_seq_reg);
    assign gap       = best_seq_reg - exp_reg;
    assign erased    = (s_reg < best_seq_reg) ? s_reg : best_seq_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        sts                = '0;
        sts.started        = started_reg;
        sts.need_zero      = (in_need == '0);
        sts.expired        = seq_older(s_reg, exp_reg);
        sts.dup            = dup_found;
        sts.any_free       = free_found;
        sts.scan_busy      = scan_busy_reg;
        sts.erased_is_base = erased_base_reg;
        sts.lo_nonempty    = (lo_count_reg != '0);
        sts.filled_done    = (filled_reg == need_reg);
        sts.hit            = exp_found;
        sts.off_lt_copy    = (off_reg < copy_reg);
        sts.off_lt_len     = (off_reg < hit_len_reg);
        sts.jump_ok        = best_found_reg && (gap > max_gap_reg);
        sts.out_free       = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg     <= MAX_GAP_RESET;
            started_reg     <= 1'b0;
            base_reg        <= '0;
            exp_reg         <= '0;
            parity_reg      <= 1'b0;
            fill_slot_reg   <= '0;
            fill_count_reg  <= '0;
            fill_active_reg <= 1'b0;
            slot_valid_reg  <= '0;
            lo_start_reg    <= '0;
            lo_count_reg    <= '0;
            scan_busy_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_gap_reg <= cfg_wdata;
            end
            if (cmd.start_push) begin
                fill_active_reg <= 1'b0;
                if (!started_reg) begin
                    base_reg    <= in_seq;
                    exp_reg     <= in_seq;
                    started_reg <= 1'b1;
                end
            end
            if (cmd.start_pull) begin
                fill_active_reg <= 1'b0;
            end
            if (cmd.push_byte && fill_active_reg
                && fill_count_reg < slot_len_reg[fill_slot_reg]) begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
            if (cmd.base_lower && seq_older(s_reg, base_reg)) begin
                base_reg <= s_reg;
            end
            if (cmd.store_free) begin
                slot_valid_reg[free_idx] <= 1'b1;
                fill_slot_reg            <= free_idx;
                fill_count_reg           <= '0;
                fill_active_reg          <= 1'b1;
            end
            if (cmd.evict && !(s_reg < best_seq_reg)) begin
                fill_slot_reg   <= best_idx_reg;
                fill_count_reg  <= '0;
                fill_active_reg <= 1'b1;
            end
            if (cmd.base_from_scan) begin
                base_reg <= best_seq_reg;
            end
            if (cmd.scan_start) begin
                scan_busy_reg <= 1'b1;
            end else if (scan_busy_reg && scan_idx_reg == SLOT_W'(SLOTS - 1)) begin
                scan_busy_reg <= 1'b0;
            end
            if (cmd.emit && cmd.emit_src == SRC_LEFT) begin
                lo_start_reg <= lo_start_reg + 1'b1;
                lo_count_reg <= lo_count_reg - 1'b1;
            end
            if (cmd.sync_exp && seq_older(exp_reg, base_reg)) begin
                exp_reg <= base_reg;
            end
            if (cmd.consume) begin
                slot_valid_reg[hit_idx_reg] <= 1'b0;
                exp_reg                     <= exp_reg + 1'b1;
                if (copy_reg < hit_len_reg) begin
                    lo_start_reg <= '0;
                    lo_count_reg <= hit_len_reg - copy_reg;
                end
            end
            if (cmd.jump) begin
                exp_reg <= best_seq_reg;
            end
            if (cmd.miss) begin
                parity_reg <= !parity_reg;
                if (parity_reg) begin
                    exp_reg <= exp_reg + 1'b1;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_push) begin
            s_reg   <= in_seq;
            len_reg <= in_len_sat;
        end
        if (cmd.start_pull) begin
            need_reg   <= in_need_sat;
            filled_reg <= '0;
        end
        if (cmd.push_byte && fill_active_reg
            && fill_count_reg < slot_len_reg[fill_slot_reg]) begin
            payload_mem[{fill_slot_reg, fill_count_reg[OFF_W-1:0]}] <= in_byte;
        end
        if (cmd.store_free) begin
            slot_seq_reg[free_idx] <= s_reg;
            slot_len_reg[free_idx] <= len_reg;
        end
        if (cmd.evict) begin
            erased_base_reg <= (erased == base_reg);
            if (!(s_reg < best_seq_reg)) begin
                slot_seq_reg[best_idx_reg] <= s_reg;
                slot_len_reg[best_idx_reg] <= len_reg;
            end
        end
        if (cmd.scan_start) begin
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            floor_reg      <= cmd.scan_floor_exp ? exp_reg : '0;
        end else if (scan_busy_reg) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (scan_take) begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= scan_idx_reg;
                best_seq_reg   <= slot_seq_reg[scan_idx_reg];
            end
        end
        if (cmd.find) begin
            hit_idx_reg <= exp_idx;
            hit_len_reg <= slot_len_reg[exp_idx];
            copy_reg    <= copy_calc;
            off_reg     <= '0;
            wr_idx_reg  <= '0;
        end
        if (cmd.lo_rd) begin
            lo_rdata_reg <= leftover_mem[lo_start_reg];
        end
        if (cmd.pl_rd) begin
            pl_rdata_reg <= payload_mem[{hit_idx_reg, off_reg[OFF_W-1:0]}];
        end
        if (cmd.lc_wr) begin
            leftover_mem[wr_idx_reg] <= pl_rdata_reg;
            wr_idx_reg               <= wr_idx_reg + 1'b1;
            off_reg                  <= off_reg + 1'b1;
        end
        if (cmd.emit) begin
            out_kind_reg   <= (cmd.emit_src != SRC_STATUS);
            out_status_reg <= (cmd.emit_src == SRC_STATUS) ? cmd.emit_status : ST_ACCEPTED;
            out_last_reg   <= (cmd.emit_src != SRC_STATUS) && (filled_reg + 1'b1 == need_reg);
            case (cmd.emit_src)
                SRC_LEFT: out_byte_reg <= lo_rdata_reg;
                SRC_PAY:  out_byte_reg <= pl_rdata_reg;
                default:  out_byte_reg <= '0;
            endcase
            if (cmd.emit_src != SRC_STATUS) begin
                filled_reg <= filled_reg + 1'b1;
            end
            if (cmd.emit_src == SRC_PAY) begin
                off_reg <= off_reg + 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = {6'd0, out_byte_reg, out_status_reg};
    assign out_last  = out_last_reg;

endmodule

[src/audio_jitter_buffer_unit.sv]
// Sequence-ordered audio jitter buffer holding 16 packets of up to 256 bytes.
// Input transactions are push-begin, payload byte or pull (s_axis_tuser).
// A payload byte is taken without leaving the idle state. A push-begin checks
// expiry, duplicates and free slots, then emits its status; when the buffer is
// full it first scans the slots for the lowest packet and evicts the lower of
// that packet and the new one, scanning again when the evicted sequence was
// the base. A pull delivers a stored byte by a memory read then the output
// register and a silence byte straight to it, visits each packet in turn, scans
// the slots per missing sequence, and copies split-off bytes into the leftover
// store. Output is registered and back-pressure stalls the block without loss.
module audio_jitter_buffer_unit
    import ajb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [SEQ_W-1:0]       cfg_wdata,     // max_gap
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // seq, payload_len, data_byte, need_bytes
    input  logic [1:0]             s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // push_status, out_byte, zero pad
    output logic                   m_axis_tuser,  // result_kind
    output logic                   m_axis_tlast
);

    cmd_t cmd;
    sts_t sts;

    ajb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ajb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
